/* rtl/terrain_height_sampler_assert.svh */
// assertion helpers for the terrain height sampler
`ifndef TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH
`define TERRAIN_HEIGHT_SAMPLER_ASSERT_SVH

// same-cycle implication
`define TSH_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define TSH_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* rtl/tsh_pkg.sv */
`timescale 1ns / 1ps
package tsh_pkg;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_GAIN = 3'd4;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [8:0] SIDE_RESET = 9'd256;
	localparam logic [8:0] MAX_SIDE = 9'd256;
	localparam logic [23:0] SCALE_RESET = 24'h010000;
	localparam int unsigned STORE_AW = 16;
	localparam int unsigned STORE_DEPTH = 65536;
	typedef logic [31:0] q16_t;
	typedef logic [STORE_AW-1:0] saddr_t;
endpackage

/* rtl/tsh_ram.sv */
`timescale 1ns / 1ps
module tsh_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/terrain_height_sampler.sv */
`timescale 1ns / 1ps
// terrain height sampler
// request channel: in_valid/in_stall with opcode, sample_addr, sample_value,
// pos_x, pos_z, height_offset. opcode 0 stores one height byte, opcode 1
// queries the interpolated height at a world position.
// result channel: out_valid/out_stall with terrain_height and in_range; every
// request yields exactly one result, in request order.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high, write only while no request is in flight.
// throughput: one request per cycle unless a held result stalls the pipeline;
// the heightmap is held in four copies of a 64k x 8 synchronous ram so the
// four corner samples are read in parallel.
// stores and reads share one pipeline stage, so reads always see earlier stores.
// when the receiver stalls, the whole pipeline holds and in_stall rises in the
// same cycle; results are never dropped.
// reset clears the pipeline and loads the default registers; heightmap
// contents are undefined until written.
module terrain_height_sampler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [15:0]                    sample_addr,
	input  logic [7:0]                     sample_value,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_z,
	input  logic signed [31:0]             height_offset,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             terrain_height,
	output logic                           in_range,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsh_pkg::*;

	logic [8:0] grid_cols_q, grid_rows_q;
	logic [23:0] inv_x_q, inv_z_q, gain_q;
	logic [8:0] cols, rows;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic inr_s2, inr_s3, inr_s4, inr_s5, inr_s6;
	q16_t off_s1, off_s2, off_s3, off_s4, off_s5, off_s6;
	saddr_t waddr_s1, waddr_s2, waddr_s3;
	logic [7:0] wval_s1, wval_s2, wval_s3;
	logic signed [56:0] px_s1, pz_s1;
	logic [8:0] col_s2, row_s2;
	logic [15:0] s_s2, t_s2, s_s3, t_s3, s_s4, t_s4;
	saddr_t ra_s3, rb_s3, rc_s3, rd_s3;
	logic [23:0] h_s5;
	logic [31:0] scl_s6;
	logic [7:0] qa, qb, qc, qd;

	logic signed [56:0] px, pz, cx, dz;
	logic [25:0] col_w, row_w;
	logic inr_c;
	saddr_t base;
	logic [16:0] st;
	logic [23:0] h_c;
	logic signed [33:0] sum;
	logic [47:0] hg;

	assign cols = (grid_cols_q > MAX_SIDE) ? MAX_SIDE : grid_cols_q;
	assign rows = (grid_rows_q > MAX_SIDE) ? MAX_SIDE : grid_rows_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= SIDE_RESET;
			grid_rows_q <= SIDE_RESET;
			inv_x_q <= SCALE_RESET;
			inv_z_q <= SCALE_RESET;
			gain_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_COLS: grid_cols_q <= cfg_data[8:0];
				REG_GRID_ROWS: grid_rows_q <= cfg_data[8:0];
				REG_INV_CELL_X: inv_x_q <= cfg_data;
				REG_INV_CELL_Z: inv_z_q <= cfg_data;
				REG_VERT_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign px = 57'(pos_x * $signed({1'b0, inv_x_q}));
	assign pz = 57'(pos_z * $signed({1'b0, inv_z_q}));

	// centre on grid, range check
	assign cx = px_s1 + $signed({17'd0, cols, 31'd0});
	assign dz = pz_s1 + $signed({17'd0, rows, 31'd0});
	assign col_w = {1'b0, cx[56:32]} + 26'd1;
	assign row_w = {1'b0, dz[56:32]} + 26'd1;
	assign inr_c = !cx[56] && !dz[56] && (col_w < {17'd0, cols}) && (row_w < {17'd0, rows});

	assign base = 16'((row_s2 * cols) + {9'd0, col_s2});

	// triangle interpolation
	assign st = {1'b0, s_s4} + {1'b0, t_s4};
	always_comb begin
		if (st <= ONE_Q16) begin
			h_c = 24'(qa * (ONE_Q16 - st)) + 24'(qb * s_s4) + 24'(qc * t_s4);
		end else begin
			h_c = 24'(qd * (st - ONE_Q16)) + 24'(qc * (ONE_Q16 - {1'b0, s_s4}))
				+ 24'(qb * (ONE_Q16 - {1'b0, t_s4}));
		end
	end

	assign hg = h_s5 * gain_q;
	assign sum = $signed({2'b00, scl_s6}) + 34'(signed'(off_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= opcode;
			off_s1 <= height_offset;
			waddr_s1 <= sample_addr;
			wval_s1 <= sample_value;
			px_s1 <= px;
			pz_s1 <= pz;

			op_s2 <= op_s1;
			off_s2 <= off_s1;
			waddr_s2 <= waddr_s1;
			wval_s2 <= wval_s1;
			inr_s2 <= inr_c;
			col_s2 <= cx[40:32];
			row_s2 <= dz[40:32];
			s_s2 <= cx[31:16];
			t_s2 <= dz[31:16];

			op_s3 <= op_s2;
			off_s3 <= off_s2;
			waddr_s3 <= waddr_s2;
			wval_s3 <= wval_s2;
			inr_s3 <= inr_s2;
			s_s3 <= s_s2;
			t_s3 <= t_s2;
			ra_s3 <= base;
			rb_s3 <= base + 16'd1;
			rc_s3 <= base + {7'd0, cols};
			rd_s3 <= base + {7'd0, cols} + 16'd1;

			op_s4 <= op_s3;
			off_s4 <= off_s3;
			inr_s4 <= inr_s3;
			s_s4 <= s_s3;
			t_s4 <= t_s3;

			op_s5 <= op_s4;
			off_s5 <= off_s4;
			inr_s5 <= inr_s4;
			h_s5 <= h_c;

			op_s6 <= op_s5;
			off_s6 <= off_s5;
			inr_s6 <= inr_s5;
			scl_s6 <= hg[47:16];

			if (op_s6 == OP_WRITE) begin
				terrain_height <= '0;
				in_range <= 1'b0;
			end else if (!inr_s6) begin
				terrain_height <= off_s6;
				in_range <= 1'b0;
			end else begin
				in_range <= 1'b1;
				if (sum > 34'sh07FFFFFFF) begin
					terrain_height <= 32'sh7FFFFFFF;
				end else if (sum < -34'sh080000000) begin
					terrain_height <= 32'sh80000000;
				end else begin
					terrain_height <= sum[31:0];
				end
			end
		end
	end

	logic st_we;
	assign st_we = adv && v_s3 && (op_s3 == OP_WRITE);

	tsh_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram_a (
		.clk(clk), .we(st_we), .waddr(waddr_s3), .wdata(wval_s3),
		.re(adv), .raddr(ra_s3), .rdata(qa));
	tsh_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram_b (
		.clk(clk), .we(st_we), .waddr(waddr_s3), .wdata(wval_s3),
		.re(adv), .raddr(rb_s3), .rdata(qb));
	tsh_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram_c (
		.clk(clk), .we(st_we), .waddr(waddr_s3), .wdata(wval_s3),
		.re(adv), .raddr(rc_s3), .rdata(qc));
	tsh_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram_d (
		.clk(clk), .we(st_we), .waddr(waddr_s3), .wdata(wval_s3),
		.re(adv), .raddr(rd_s3), .rdata(qd));
endmodule

/* rtl/tsh_checker.sv */
`timescale 1ns / 1ps
`include "terrain_height_sampler_assert.svh"
module tsh_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] terrain_height,
	input logic        in_range,
	input logic        cfg_ready
);
	// a held result freezes the pipeline, so requests must be held off
	`TSH_ASSERT_NOW(a_stall_back, clk, arst_n, out_valid && out_stall, in_stall)
	`TSH_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(terrain_height) && $stable(in_range))
	`TSH_ASSERT_NOW(a_cfg_rdy, clk, arst_n, 1'b1, cfg_ready)
endmodule

bind terrain_height_sampler tsh_port_props u_tsh_port_props (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .terrain_height(terrain_height), .in_range(in_range),
	.cfg_ready(cfg_ready));

/* verif/tsh_checker.sv */
`timescale 1ns / 1ps
module tsh_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] sample_addr,
	input  logic [7:0]  sample_value,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_z,
	input  logic [31:0] height_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] terrain_height,
	input  logic        in_range,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [tsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          mismatches,
	output int          pending
);
	import tsh_pkg::*;

	typedef struct packed {
		q16_t height;
		logic hit;
	} height_res_t;

	logic [7:0] heightmap [STORE_DEPTH];
	logic [8:0] cols_reg, rows_reg;
	logic [23:0] inv_x_reg, inv_z_reg, gain_reg;
	height_res_t expected_heights [$];

	function automatic height_res_t sample_height(q16_t px, q16_t pz, q16_t off);
		longint cols, rows, c, d, col, row, s, t, a, b, cc, dd, h, sum;
		saddr_t base;
		height_res_t res;
		cols = (cols_reg > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(cols_reg);
		rows = (rows_reg > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(rows_reg);
		res.height = off;
		res.hit = 1'b0;
		c = longint'($signed(px)) * longint'(inv_x_reg) + (cols <<< 31);
		d = longint'($signed(pz)) * longint'(inv_z_reg) + (rows <<< 31);
		if (c < 0 || d < 0)
			return res;
		col = c >>> 32;
		row = d >>> 32;
		if (col + 1 >= cols || row + 1 >= rows)
			return res;
		s = (c >>> 16) & 64'hFFFF;
		t = (d >>> 16) & 64'hFFFF;
		base = saddr_t'(row * cols + col);
		a = heightmap[base];
		b = heightmap[saddr_t'(base + 1)];
		cc = heightmap[saddr_t'(base + cols)];
		dd = heightmap[saddr_t'(base + cols + 1)];
		if (s + t <= 65536)
			h = a * (65536 - s - t) + b * s + cc * t;
		else
			h = dd * (s + t - 65536) + cc * (65536 - s) + b * (65536 - t);
		sum = ((h * longint'(gain_reg)) >>> 16) + longint'($signed(off));
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		res.height = q16_t'(sum);
		res.hit = 1'b1;
		return res;
	endfunction

	assign pending = expected_heights.size();

	always @(posedge clk or negedge arst_n) begin
		height_res_t exp_res;
		if (!arst_n) begin
			cols_reg <= SIDE_RESET;
			rows_reg <= SIDE_RESET;
			inv_x_reg <= SCALE_RESET;
			inv_z_reg <= SCALE_RESET;
			gain_reg <= SCALE_RESET;
			mismatches <= 0;
			expected_heights.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GRID_COLS: cols_reg <= cfg_data[8:0];
					REG_GRID_ROWS: rows_reg <= cfg_data[8:0];
					REG_INV_CELL_X: inv_x_reg <= cfg_data;
					REG_INV_CELL_Z: inv_z_reg <= cfg_data;
					REG_VERT_GAIN: gain_reg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_WRITE) begin
					heightmap[sample_addr] = sample_value;
					expected_heights.insert(expected_heights.size(), height_res_t'(0));
				end else begin
					expected_heights.insert(expected_heights.size(),
						sample_height(pos_x, pos_z, height_offset));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_heights.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: height %h in_range %b",
							terrain_height, in_range);
					mismatches <= mismatches + 1;
				end else begin
					exp_res = expected_heights.pop_front();
					if (exp_res.height !== terrain_height || exp_res.hit !== in_range) begin
						if (mismatches < 10)
							$display("mismatch: height exp %h got %h, in_range exp %b got %b",
								exp_res.height, terrain_height, exp_res.hit, in_range);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
	import tsh_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_WRITE;
	logic [15:0] sample_addr = '0;
	logic [7:0] sample_value = '0;
	logic [31:0] pos_x = '0;
	logic [31:0] pos_z = '0;
	logic [31:0] height_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] terrain_height;
	logic in_range;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int mismatches, pending;
	int burst_left = 0;
	int hold_count = 0;
	int idle_cycles = 0;
	int cur_cols = 256, cur_rows = 256;
	int cur_inv_x = 65536, cur_inv_z = 65536;
	bit written [STORE_DEPTH];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	terrain_height_sampler u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .sample_addr(sample_addr), .sample_value(sample_value),
		.pos_x(pos_x), .pos_z(pos_z), .height_offset(height_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.terrain_height(terrain_height), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tsh_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .sample_addr(sample_addr), .sample_value(sample_value),
		.pos_x(pos_x), .pos_z(pos_z), .height_offset(height_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.terrain_height(terrain_height), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	// receiver stall pattern, with long hold-off on request
	always @(posedge clk) begin
		int mode_left, mode, hold_left, hold_seen;
		if (hold_count != hold_seen) begin
			hold_seen = hold_count;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left <= 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= (mode_left % 4 == 0);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_request(logic op, logic [15:0] addr, logic [7:0] val,
			logic [31:0] px, logic [31:0] pz, logic [31:0] off);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		sample_addr <= addr;
		sample_value <= val;
		pos_x <= px;
		pos_z <= pz;
		height_offset <= off;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
	endtask

	task automatic send_write(logic [15:0] addr, logic [7:0] val);
		written[addr] = 1'b1;
		send_request(OP_WRITE, addr, val, 32'($urandom()), 32'($urandom()),
			32'($urandom()));
	endtask

	// an unwritten corner that a query at this position would read
	function automatic bit missing_corner(logic [31:0] px, logic [31:0] pz,
			output logic [15:0] addr);
		longint c, d, col, row, base;
		longint corner [4];
		addr = '0;
		if (cur_cols < 2 || cur_rows < 2)
			return 1'b0;
		c = longint'($signed(px)) * longint'(cur_inv_x) + (longint'(cur_cols) <<< 31);
		d = longint'($signed(pz)) * longint'(cur_inv_z) + (longint'(cur_rows) <<< 31);
		if (c < 0 || d < 0)
			return 1'b0;
		col = c >>> 32;
		row = d >>> 32;
		if (col + 1 >= cur_cols || row + 1 >= cur_rows)
			return 1'b0;
		base = row * cur_cols + col;
		corner[0] = base;
		corner[1] = base + 1;
		corner[2] = base + cur_cols;
		corner[3] = base + cur_cols + 1;
		for (int k = 0; k < 4; k++) begin
			if (!written[16'(corner[k])]) begin
				addr = 16'(corner[k]);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic send_query(logic [31:0] px, logic [31:0] pz, logic [31:0] off);
		logic [15:0] addr;
		while (missing_corner(px, pz, addr))
			send_write(addr, 8'($urandom()));
		send_request(OP_QUERY, '0, '0, px, pz, off);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(int cols, int rows, int inv_x, int inv_z, int gain);
		drain();
		write_reg(REG_GRID_COLS, 24'(cols));
		write_reg(REG_GRID_ROWS, 24'(rows));
		write_reg(REG_INV_CELL_X, 24'(inv_x));
		write_reg(REG_INV_CELL_Z, 24'(inv_z));
		write_reg(REG_VERT_GAIN, 24'(gain));
		cur_cols = cols > int'(MAX_SIDE) ? int'(MAX_SIDE) : cols;
		cur_rows = rows > int'(MAX_SIDE) ? int'(MAX_SIDE) : rows;
		cur_inv_x = inv_x;
		cur_inv_z = inv_z;
	endtask

	// mostly positions that land on the grid, some anywhere
	function automatic logic [31:0] pick_pos(int side, int inv);
		longint target, p;
		if (inv == 0 || $urandom_range(0, 3) == 0)
			return $urandom();
		target = (longint'($urandom_range(0, side * 65536)) - longint'(side) * 32768) <<< 16;
		p = target / inv;
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	// mostly addresses inside the current grid
	function automatic logic [15:0] pick_addr();
		if (cur_cols * cur_rows > 0 && $urandom_range(0, 3) != 0)
			return 16'($urandom_range(0, cur_cols * cur_rows - 1));
		return 16'($urandom());
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF);
			1: return 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_requests(int count);
		logic [31:0] px, pz;
		logic [15:0] addr;
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 3) begin
				send_write(pick_addr(), 8'($urandom()));
			end else begin
				px = pick_pos(cur_cols, cur_inv_x);
				pz = pick_pos(cur_rows, cur_inv_z);
				while (missing_corner(px, pz, addr)) begin
					send_write(addr, 8'($urandom()));
					sent++;
				end
				send_request(OP_QUERY, '0, '0, px, pz, pick_offset());
			end
			sent++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_write(16'h0000, 8'h00);
		send_write(16'hFFFF, 8'hFF);
		send_write(16'h8081, 8'hFF);
		send_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_query(32'h0000_8000, 32'h0000_8000, 32'h0000_0000);
		send_query(32'h0000_8000, 32'h0000_8001, 32'h0001_0000);
		send_query(32'h0000_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF);
		send_query(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
		send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
		send_query(32'hFF80_0000, 32'hFF80_0000, 32'h0000_0000);
		send_query(32'hFF7F_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_query(32'h007E_FFFF, 32'h007E_FFFF, 32'h8000_0000);
		send_query(32'h007F_0000, 32'h0000_0000, 32'h0000_0000);
		send_query(32'h0000_0000, 32'h007F_0000, 32'h0000_0000);

		set_grid(256, 256, 65536, 65536, 65536);
		random_requests(250);
		set_grid(2, 2, 65536, 65536, 24'hFFFFFF);
		send_query(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_0000);
		send_query(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		random_requests(250);
		set_grid(511, 300, 24'hFFFFFF, 1, 0);
		random_requests(250);
		set_grid(0, 1, 65536, 65536, 65536);
		random_requests(150);
		set_grid(16, 8, 24'h001000, 24'h080000, 24'h00C000);
		// hold the receiver off while requests keep coming
		hold_count++;
		random_requests(250);
		drain();
		random_requests(150);
		set_grid(200, 256, 0, 24'h000100, 24'h123456);
		random_requests(250);
		set_grid(256, 256, 24'h018000, 24'h00A000, 24'h020000);
		hold_count++;
		random_requests(250);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/tsh_pkg.sv
rtl/tsh_ram.sv
rtl/terrain_height_sampler.sv
rtl/tsh_checker.sv
verif/tsh_checker.sv
verif/tb.sv
